>>> sv/cas_pkg.sv
// ----------------------------------------------------------------------------
// Cave smoothing package
// Shared widths, reset values, register indexes and types for the cave
// smoothing step.
// ----------------------------------------------------------------------------
package cas_pkg;

   // Register field widths.
   localparam int GRID_WIDTH_W  = 9;
   localparam int GRID_HEIGHT_W = 13;
   localparam int THRESHOLD_W   = 4;

   // Configuration port widths.
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 13;

   // Register reset values.
   localparam logic [GRID_WIDTH_W-1:0]  GRID_WIDTH_RESET  = 9'd64;
   localparam logic [GRID_HEIGHT_W-1:0] GRID_HEIGHT_RESET = 13'd64;
   localparam logic [THRESHOLD_W-1:0]   THRESHOLD_RESET   = 4'd5;

   // Default row capacity of the line memories.
   localparam int MAX_WIDTH_DEFAULT = 256;

   // Row counter holds up to height plus one while the last rows drain.
   localparam int ROW_W = GRID_HEIGHT_W + 1;

   // Wall count of a 3x3 window, 0 to 9.
   localparam int COUNT_W = 4;

   // Cell values.
   localparam logic FLOOR = 1'b0;
   localparam logic WALL  = 1'b1;

   // Register indexes on the configuration port.
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_GRID_WIDTH      = 2'd0,
      CSR_GRID_HEIGHT     = 2'd1,
      CSR_CLEAR_THRESHOLD = 2'd2
   } csr_index_type;

   // Where the cell being finished sits in the grid.
   typedef struct packed {
      logic has_out;  // a result is produced for this transfer
      logic top;      // finished cell is in the first row
      logic bottom;   // finished cell is in the last row
      logic left;     // finished cell is in the first column
      logic right;    // finished cell is in the last column
      logic last;     // finished cell is the final cell of the grid
   } pos_type;

endpackage

>>> sv/cas_if.sv
// ----------------------------------------------------------------------------
// Cave smoothing channels
// Valid/ready interfaces for the cell stream and the result stream.
// ----------------------------------------------------------------------------
interface cas_req_if;
   logic valid;
   logic ready;
   logic cell_wall;
   logic pad;

   modport source (output valid, output cell_wall, output pad, input ready);
   modport sink (input valid, input cell_wall, input pad, output ready);
endinterface

interface cas_rsp_if;
   logic valid;
   logic ready;
   logic new_wall;
   logic was_cleared;
   logic frame_last;
   logic any_cleared;

   modport source (output valid, output new_wall, output was_cleared, output frame_last,
                   output any_cleared, input ready);
   modport sink (input valid, input new_wall, input was_cleared, input frame_last,
                 input any_cleared, output ready);
endinterface

>>> sv/cas_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered, read-first data.
// ----------------------------------------------------------------------------
module cas_ram #(
   parameter int DATA_W = 1,
   parameter int DEPTH  = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [DATA_W-1:0]        wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [DATA_W-1:0]        rdata
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rdata_ff;

   // Read returns the old contents when both ports hit the same entry.
   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem[raddr];
      end
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   assign rdata = rdata_ff;

endmodule

>>> sv/cas_raster.sv
// ----------------------------------------------------------------------------
// Cave smoothing raster tracker
// Counts the raster position of incoming cells and derives the position of
// the cell that is finished one row plus one cell behind.
// ----------------------------------------------------------------------------
module cas_raster #(
   parameter int MAX_WIDTH = cas_pkg::MAX_WIDTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [cas_pkg::GRID_WIDTH_W-1:0]  grid_width,
   input  logic [cas_pkg::GRID_HEIGHT_W-1:0] grid_height,
   input  logic                              restart,
   input  logic                              advance,
   output logic [$clog2(MAX_WIDTH)-1:0]      col_in,
   output logic [$clog2(MAX_WIDTH)-1:0]      col_out,
   output cas_pkg::pos_type                  pos
);
   import cas_pkg::*;

   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int WID_W = $clog2(MAX_WIDTH + 1);
   localparam int CMP_W = (WID_W > GRID_WIDTH_W) ? WID_W : GRID_WIDTH_W;

   logic [COL_W-1:0]         col_ff, col_in_w;
   logic [ROW_W-1:0]         row_ff, row_in;
   logic [CMP_W-1:0]         width_x;
   logic [WID_W-1:0]         width_eff;
   logic [ROW_W-1:0]         height_eff;
   logic                     col_wrap;
   logic                     not_first_col;
   pos_type                  pos_w;

   // Width clamps to 1..MAX_WIDTH, height zero acts as one.
   always_comb begin
      width_x = CMP_W'(grid_width);
      if (width_x == '0) begin
         width_eff = WID_W'(1);
      end else if (width_x > CMP_W'(MAX_WIDTH)) begin
         width_eff = WID_W'(MAX_WIDTH);
      end else begin
         width_eff = WID_W'(width_x);
      end
      height_eff = (grid_height == '0) ? ROW_W'(1) : ROW_W'(grid_height);
   end

   // Position of the finished cell, one row plus one cell behind the input.
   always_comb begin
      not_first_col = (col_ff != '0);
      if (not_first_col) begin
         col_in_w       = col_ff - COL_W'(1);
         pos_w.has_out  = (row_ff >= ROW_W'(1));
         pos_w.top      = (row_ff == ROW_W'(1));
         pos_w.bottom   = (row_ff == height_eff);
      end else begin
         col_in_w       = COL_W'(width_eff - WID_W'(1));
         pos_w.has_out  = (row_ff >= ROW_W'(2));
         pos_w.top      = (row_ff == ROW_W'(2));
         pos_w.bottom   = ({1'b0, row_ff} == ({1'b0, height_eff} + (ROW_W + 1)'(1)));
      end
      pos_w.left  = (col_in_w == '0);
      pos_w.right = (WID_W'(col_in_w) == (width_eff - WID_W'(1)));
      pos_w.last  = pos_w.has_out && pos_w.bottom && pos_w.right;
      col_wrap    = ((WID_W'(col_ff) + WID_W'(1)) == width_eff);
   end

   // Raster counters; the transfer that finishes the grid starts a new frame.
   always_ff @(posedge clock) begin
      if (reset || restart) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (advance) begin
         if (pos_w.last) begin
            col_ff <= '0;
            row_ff <= '0;
         end else if (col_wrap) begin
            col_ff <= '0;
            row_ff <= row_ff + ROW_W'(1);
         end else begin
            col_ff <= col_ff + COL_W'(1);
         end
      end
   end

   assign col_in  = col_ff;
   assign col_out = col_in_w;
   assign pos     = pos_w;

endmodule

>>> sv/cas_kernel.sv
// ----------------------------------------------------------------------------
// Cave smoothing kernel
// Counts the walls of a masked 3x3 window and applies the clear rule.
// ----------------------------------------------------------------------------
module cas_kernel (
   input  logic [8:0]                      window,
   input  logic [cas_pkg::THRESHOLD_W-1:0] threshold,
   input  logic                            center,
   output logic                            cleared,
   output logic                            new_wall
);
   import cas_pkg::*;

   logic [COUNT_W-1:0] count;

   // Nine-bit population count.
   always_comb begin
      count = '0;
      for (int i = 0; i < 9; i++) begin
         count = count + COUNT_W'(window[i]);
      end
   end

   // A cell with too few walls around it becomes floor.
   assign cleared  = (count < threshold);
   assign new_wall = cleared ? FLOOR : center;

endmodule

>>> sv/cave_automaton_smoothing_step.sv
// ----------------------------------------------------------------------------
// Cave smoothing step
// One in-place pass of a 3x3 wall-count automaton over a raster cell stream.
// ----------------------------------------------------------------------------
// Cells enter on req_ch in raster order, one per transfer, and the block takes
// one transfer every clock cycle as long as the result side keeps up.
// A cell's result leaves on rsp_ch one row plus one cell of transfers later:
// the transfer that completes its window waits in the working stage and loads
// the output register as it leaves, and the result is visible in the following
// cycle. After the last cell of a frame the host sends grid_width+1 pad
// transfers to drain the remaining results; the final one carries frame_last
// and any_cleared. Items before the first result produce nothing.
// Two line memories of MAX_WIDTH one-bit entries hold the updated cells of
// the row above and the raw cells of the finished cell's own row, and each
// is read once per transfer.
// Reset clears the position, the registers return to 64 x 64 with a
// threshold of 5, and no result is pending. Any register write restarts the
// frame at its first cell. When rsp_ch stalls, the result waits in the output
// register; one more transfer is held in the working stage, and once it too
// has a result, req_ch.ready drops until the result is taken.
// ----------------------------------------------------------------------------
module cave_automaton_smoothing_step #(
   parameter int MAX_WIDTH = cas_pkg::MAX_WIDTH_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   cas_req_if.sink                         req_ch,
   cas_rsp_if.source                       rsp_ch,
   input  logic                            csr_we,
   input  logic [cas_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [cas_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import cas_pkg::*;

   localparam int COL_W = $clog2(MAX_WIDTH);

   // Configuration registers.
   logic [GRID_WIDTH_W-1:0]  grid_width_ff;
   logic [GRID_HEIGHT_W-1:0] grid_height_ff;
   logic [THRESHOLD_W-1:0]   threshold_ff;
   logic                     restart;

   // Input side.
   logic             accept;
   logic             cur_in;
   logic [COL_W-1:0] col_in, col_out;
   pos_type          pos;

   // Working stage.
   logic             s1_valid_ff;
   pos_type          s1_pos_ff;
   logic [COL_W-1:0] s1_col_ff;
   logic             s1_cur_ff;
   logic             fwd_hit_ff;
   logic             fwd_val_ff;
   logic             s1_adv;
   logic             out_load;
   logic             raw_rd, upd_rd;
   logic [2:0]       new_col, left_col, mid_col, right_col;
   logic [2:0]       row_mask;
   logic [2:0]       col_a_ff, col_b_ff;
   logic             prev_new_ff;
   logic             narrow;
   logic [8:0]       window;
   logic             cleared, new_wall;
   logic             changed_ff;

   // Output register.
   logic rsp_valid_ff;
   logic rsp_new_wall_ff, rsp_was_cleared_ff, rsp_frame_last_ff, rsp_any_cleared_ff;

   // Register writes; a write to a known register restarts the frame.
   assign restart = csr_we && ((csr_index == CSR_GRID_WIDTH) ||
                               (csr_index == CSR_GRID_HEIGHT) ||
                               (csr_index == CSR_CLEAR_THRESHOLD));

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_width_ff  <= GRID_WIDTH_RESET;
         grid_height_ff <= GRID_HEIGHT_RESET;
         threshold_ff   <= THRESHOLD_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_GRID_WIDTH:      grid_width_ff  <= csr_wdata[GRID_WIDTH_W-1:0];
            CSR_GRID_HEIGHT:     grid_height_ff <= csr_wdata[GRID_HEIGHT_W-1:0];
            CSR_CLEAR_THRESHOLD: threshold_ff   <= csr_wdata[THRESHOLD_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Handshake: the working stage drains into the output register or retires.
   assign s1_adv   = s1_valid_ff && (!s1_pos_ff.has_out || !rsp_valid_ff || rsp_ch.ready);
   assign out_load = s1_adv && s1_pos_ff.has_out;
   assign req_ch.ready = !s1_valid_ff || s1_adv;
   assign accept   = req_ch.valid && req_ch.ready;
   assign cur_in   = req_ch.cell_wall && !req_ch.pad;

   cas_raster #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_raster (
      .clock       (clock),
      .reset       (reset),
      .grid_width  (grid_width_ff),
      .grid_height (grid_height_ff),
      .restart     (restart),
      .advance     (accept),
      .col_in      (col_in),
      .col_out     (col_out),
      .pos         (pos)
   );

   // Raw cells of the latest input row, indexed by column.
   cas_ram #(
      .DATA_W (1),
      .DEPTH  (MAX_WIDTH)
   ) u_raw_line (
      .clock (clock),
      .we    (accept),
      .waddr (col_in),
      .wdata (cur_in),
      .re    (accept),
      .raddr (col_in),
      .rdata (raw_rd)
   );

   // Updated cells of the latest finished row, indexed by column.
   cas_ram #(
      .DATA_W (1),
      .DEPTH  (MAX_WIDTH)
   ) u_upd_line (
      .clock (clock),
      .we    (out_load),
      .waddr (s1_col_ff),
      .wdata (new_wall),
      .re    (accept),
      .raddr (col_in),
      .rdata (upd_rd)
   );

   // Working stage control, including the forward of a same-edge line write.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         fwd_hit_ff  <= 1'b0;
      end else begin
         if (accept) begin
            s1_valid_ff <= 1'b1;
            fwd_hit_ff  <= out_load && (s1_col_ff == col_in);
         end else if (s1_adv) begin
            s1_valid_ff <= 1'b0;
         end
      end
   end

   // Working stage payload.
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pos_ff  <= pos;
         s1_col_ff  <= col_out;
         s1_cur_ff  <= cur_in;
         fwd_val_ff <= new_wall;
      end
   end

   // Assemble the window; bit 0 of a column is the top row, bit 2 the bottom.
   always_comb begin
      new_col   = {s1_cur_ff, raw_rd, fwd_hit_ff ? fwd_val_ff : upd_rd};
      narrow    = s1_pos_ff.left && s1_pos_ff.right;
      row_mask  = {!s1_pos_ff.bottom, 1'b1, !s1_pos_ff.top};
      left_col  = {col_a_ff[2], prev_new_ff, col_a_ff[0]} & {3{!s1_pos_ff.left}} & row_mask;
      mid_col   = {col_b_ff[2], col_b_ff[1], narrow ? prev_new_ff : col_b_ff[0]} & row_mask;
      right_col = new_col & {3{!s1_pos_ff.right}} & row_mask;
      window    = {left_col, mid_col, right_col};
   end

   cas_kernel u_kernel (
      .window    (window),
      .threshold (threshold_ff),
      .center    (col_b_ff[1]),
      .cleared   (cleared),
      .new_wall  (new_wall)
   );

   // Column history and the previous result for the in-place update.
   always_ff @(posedge clock) begin
      if (s1_adv) begin
         col_a_ff    <= col_b_ff;
         col_b_ff    <= new_col;
         prev_new_ff <= new_wall;
      end
   end

   // Frame-wide clear flag.
   always_ff @(posedge clock) begin
      if (reset || restart) begin
         changed_ff <= 1'b0;
      end else if (out_load) begin
         changed_ff <= s1_pos_ff.last ? 1'b0 : (changed_ff || cleared);
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_new_wall_ff    <= new_wall;
         rsp_was_cleared_ff <= cleared;
         rsp_frame_last_ff  <= s1_pos_ff.last;
         rsp_any_cleared_ff <= s1_pos_ff.last && (changed_ff || cleared);
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.new_wall    = rsp_new_wall_ff;
   assign rsp_ch.was_cleared = rsp_was_cleared_ff;
   assign rsp_ch.frame_last  = rsp_frame_last_ff;
   assign rsp_ch.any_cleared = rsp_any_cleared_ff;

endmodule

>>> sv/cas_checker.sv
// ----------------------------------------------------------------------------
// Cave smoothing checker
// Port-level assertions on the result stream, bound to the top level.
// ----------------------------------------------------------------------------
module cas_checker (
   input logic clock,
   input logic reset,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic new_wall,
   input logic was_cleared,
   input logic frame_last,
   input logic any_cleared
);

   // A stalled result keeps its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid &&
         $stable(new_wall) && $stable(was_cleared) &&
         $stable(frame_last) && $stable(any_cleared))
      else $error("result changed while stalled");

   // The frame summary only rides on the final cell.
   a_any_on_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && any_cleared |-> frame_last)
      else $error("any_cleared outside frame_last");

   // A cleared cell is always floor.
   a_cleared_floor: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && was_cleared |-> !new_wall)
      else $error("cleared cell is not floor");

   // A cleared final cell must show in the frame summary.
   a_last_summary: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && frame_last && was_cleared |-> any_cleared)
      else $error("frame summary misses cleared final cell");

   // Reset leaves no result pending.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result pending after reset");

endmodule

bind cave_automaton_smoothing_step cas_checker u_cas_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_ch.valid),
   .rsp_ready   (rsp_ch.ready),
   .new_wall    (rsp_ch.new_wall),
   .was_cleared (rsp_ch.was_cleared),
   .frame_last  (rsp_ch.frame_last),
   .any_cleared (rsp_ch.any_cleared)
);
